// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define SSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge outside of reset.
`define SSP_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/ssp_pkg.sv =====
package ssp_pkg;

  localparam int unsigned NodeW        = 6;
  localparam int unsigned DistW        = 22;
  localparam int unsigned WeightW      = 16;
  localparam int unsigned CountW       = 7;
  localparam int unsigned DefMaxNodes  = 64;
  localparam int unsigned DefMaxEdges  = 256;
  localparam logic [DistW-1:0]  DistMax      = 22'h3FFFFF;
  localparam logic [CountW-1:0] NodeCountRst = 7'd64;
  localparam logic [NodeW-1:0]  SourceRst    = 6'd0;

  // Configuration register indexes.
  localparam int unsigned RegNodeCount = 0;
  localparam int unsigned RegSource    = 1;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_RUN   = 2'd2
  } ssp_op_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [NodeW-1:0]   from_node;
    logic [NodeW-1:0]   to_node;
    logic [WeightW-1:0] weight;
  } ssp_in_t;

  typedef struct packed {
    logic [NodeW-1:0] node;
    logic [DistW-1:0] distance;
    logic             reached;
    logic             all_reached;
    logic             edges_dropped;
    logic             last;
  } ssp_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_SETTLE,
    ST_EDGE_RD,
    ST_EDGE_DST,
    ST_EDGE_UPD,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_OUT_WAIT
  } ssp_state_e;

  typedef struct packed {
    logic add;
    logic clear;
    logic init;
    logic scan_start;
    logic scan;
    logic settle;
    logic edge_rd;
    logic edge_dst;
    logic edge_upd;
    logic out_start;
    logic out_rd;
    logic out_ld;
    logic out_next;
  } ssp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic best_valid;
    logic edge_done;
    logic out_fire;
    logic out_last;
  } ssp_stat_t;

endpackage

// ===== hw/rtl/ssp_ctrl.sv =====
module ssp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_op_i,
  output logic              in_ready_o,
  input  ssp_pkg::ssp_stat_t stat_i,
  output ssp_pkg::ssp_cmd_t  cmd_o
);
  import ssp_pkg::*;

  ssp_state_e state_q, state_d;
  logic       in_fire;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (ssp_op_e'(in_op_i) == OP_RUN)) begin
          state_d = ST_INIT;
        end
      end
      ST_INIT:     state_d = ST_SCAN;
      ST_SCAN: begin
        if (stat_i.scan_done) begin
          state_d = stat_i.best_valid ? ST_SETTLE : ST_OUT_RD;
        end
      end
      ST_SETTLE:   state_d = ST_EDGE_RD;
      ST_EDGE_RD:  state_d = stat_i.edge_done ? ST_SCAN : ST_EDGE_DST;
      ST_EDGE_DST: state_d = ST_EDGE_UPD;
      ST_EDGE_UPD: state_d = ST_EDGE_RD;
      ST_OUT_RD:   state_d = ST_OUT_LD;
      ST_OUT_LD:   state_d = ST_OUT_WAIT;
      ST_OUT_WAIT: begin
        if (stat_i.out_fire) begin
          state_d = stat_i.out_last ? ST_IDLE : ST_OUT_RD;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (ssp_op_e'(in_op_i))
            OP_ADD:   cmd_o.add   = 1'b1;
            OP_CLEAR: cmd_o.clear = 1'b1;
            default:  ;
          endcase
        end
      end
      ST_INIT: begin
        cmd_o.init       = 1'b1;
        cmd_o.scan_start = 1'b1;
      end
      ST_SCAN: begin
        cmd_o.scan      = 1'b1;
        cmd_o.out_start = stat_i.scan_done && !stat_i.best_valid;
      end
      ST_SETTLE:   cmd_o.settle = 1'b1;
      ST_EDGE_RD: begin
        cmd_o.edge_rd    = !stat_i.edge_done;
        cmd_o.scan_start = stat_i.edge_done;
      end
      ST_EDGE_DST: cmd_o.edge_dst = 1'b1;
      ST_EDGE_UPD: cmd_o.edge_upd = 1'b1;
      ST_OUT_RD:   cmd_o.out_rd   = 1'b1;
      ST_OUT_LD:   cmd_o.out_ld   = 1'b1;
      ST_OUT_WAIT: cmd_o.out_next = stat_i.out_fire && !stat_i.out_last;
      default:     ;
    endcase
  end

endmodule

// ===== hw/rtl/ssp_dp.sv =====
`include "assert_macros.svh"

module ssp_dp #(
  parameter int unsigned MAX_NODES = ssp_pkg::DefMaxNodes,
  parameter int unsigned MAX_EDGES = ssp_pkg::DefMaxEdges
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ssp_pkg::ssp_cmd_t              cmd_i,
  output ssp_pkg::ssp_stat_t             stat_o,
  input  ssp_pkg::ssp_in_t               in_data_i,
  input  logic [ssp_pkg::CountW-1:0]    node_count_i,
  input  logic [ssp_pkg::NodeW-1:0]     source_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ssp_pkg::ssp_out_t              out_data_o
);
  import ssp_pkg::*;

  localparam int unsigned NW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned CW = $clog2(MAX_NODES + 1);
  localparam int unsigned AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned EW = $clog2(MAX_EDGES + 1);
  localparam int unsigned EdgeBits = 2 * NodeW + WeightW;

  // Edge store and per-node distance memory.
  logic [EdgeBits-1:0] edge_mem [MAX_EDGES];
  logic [DistW-1:0]    dist_mem [MAX_NODES];

  logic [EW-1:0]        ecnt_q, eidx_q;
  logic                 ovf_q;
  logic [EdgeBits-1:0]  erd_q;
  logic [NodeW-1:0]     e_start, e_end;
  logic [WeightW-1:0]   e_len;

  logic [CW-1:0]        n_q, idx_q, oidx_q;
  logic [NW-1:0]        pidx_q, bu_q;
  logic                 pend_q, bv_q;
  logic [DistW-1:0]     bd_q, rd_q;
  logic [MAX_NODES-1:0] found_q, settled_q, allf_vec, found_init;

  logic [CountW-1:0]    n_eff;
  logic [NW-1:0]        rd_addr, wr_addr, v_idx;
  logic                 wr_en, cand, e_ok;
  logic [DistW-1:0]     wr_data;
  logic [DistW:0]       sum;
  logic [DistW-1:0]     nd;
  logic                 out_valid_q;
  ssp_out_t             out_q;

  assign {e_start, e_end, e_len} = erd_q;
  assign v_idx = e_end[NW-1:0];

  always_comb begin
    if (node_count_i == '0) begin
      n_eff = CountW'(1);
    end else if (node_count_i > CountW'(MAX_NODES)) begin
      n_eff = CountW'(MAX_NODES);
    end else begin
      n_eff = node_count_i;
    end
  end

  // Reach bits at the start of a run: only the source, when it lies in the graph.
  always_comb begin
    found_init = '0;
    if (CountW'(source_i) < n_eff) begin
      found_init[source_i[NW-1:0]] = 1'b1;
    end
  end

  // Saturating relax candidate.
  assign sum = {1'b0, bd_q} + (DistW + 1)'(e_len);
  assign nd  = (sum > {1'b0, DistMax}) ? DistMax : sum[DistW-1:0];
  assign e_ok = (e_start == NodeW'(bu_q)) && (CountW'(e_end) < CountW'(n_q))
                && !settled_q[v_idx];
  assign cand = found_q[pidx_q] && !settled_q[pidx_q];

  always_comb begin
    for (int k = 0; k < MAX_NODES; k++) begin
      allf_vec[k] = found_q[k] || (CW'(k) >= n_q);
    end
  end

  always_comb begin
    rd_addr = idx_q[NW-1:0];
    if (cmd_i.edge_dst) begin
      rd_addr = v_idx;
    end else if (cmd_i.out_rd) begin
      rd_addr = oidx_q[NW-1:0];
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = source_i[NW-1:0];
    wr_data = '0;
    if (cmd_i.init) begin
      wr_en = 1'b1;
    end else if (cmd_i.edge_upd && e_ok && (!found_q[v_idx] || nd < rd_q)) begin
      wr_en   = 1'b1;
      wr_addr = v_idx;
      wr_data = nd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add && (ecnt_q < EW'(MAX_EDGES))) begin
      edge_mem[ecnt_q[AW-1:0]] <= {in_data_i.from_node, in_data_i.to_node, in_data_i.weight};
    end
    if (cmd_i.edge_rd) begin
      erd_q <= edge_mem[eidx_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      dist_mem[wr_addr] <= wr_data;
    end
    rd_q <= dist_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecnt_q      <= '0;
      ovf_q       <= 1'b0;
      eidx_q      <= '0;
      n_q         <= CW'(MAX_NODES);
      idx_q       <= '0;
      oidx_q      <= '0;
      pidx_q      <= '0;
      pend_q      <= 1'b0;
      bv_q        <= 1'b0;
      bu_q        <= '0;
      found_q     <= '0;
      settled_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.add) begin
        if (ecnt_q < EW'(MAX_EDGES)) begin
          ecnt_q <= ecnt_q + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.clear) begin
        ecnt_q <= '0;
        ovf_q  <= 1'b0;
      end
      if (cmd_i.init) begin
        n_q       <= CW'(n_eff);
        settled_q <= '0;
        found_q   <= found_init;
      end
      if (cmd_i.scan_start) begin
        idx_q  <= '0;
        pend_q <= 1'b0;
        bv_q   <= 1'b0;
      end
      if (cmd_i.scan) begin
        pend_q <= (idx_q != n_q);
        pidx_q <= idx_q[NW-1:0];
        if (idx_q != n_q) begin
          idx_q <= idx_q + 1'b1;
        end
        if (pend_q && cand && (!bv_q || rd_q < bd_q)) begin
          bv_q <= 1'b1;
          bu_q <= pidx_q;
        end
      end
      if (cmd_i.settle) begin
        settled_q[bu_q] <= 1'b1;
        eidx_q          <= '0;
      end
      if (cmd_i.edge_upd) begin
        eidx_q <= eidx_q + 1'b1;
        if (wr_en) begin
          found_q[v_idx] <= 1'b1;
        end
      end
      if (cmd_i.out_start) begin
        oidx_q <= '0;
      end
      if (cmd_i.out_next) begin
        oidx_q <= oidx_q + 1'b1;
      end
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Best distance of the node in the lead; no reset needed.
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && pend_q && cand && (!bv_q || rd_q < bd_q)) begin
      bd_q <= rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_q.node          <= NodeW'(oidx_q);
      out_q.distance      <= found_q[oidx_q[NW-1:0]] ? rd_q : DistMax;
      out_q.reached       <= found_q[oidx_q[NW-1:0]];
      out_q.last          <= (CW'(oidx_q + 1'b1) == n_q);
      out_q.all_reached   <= (CW'(oidx_q + 1'b1) == n_q) && (&allf_vec);
      out_q.edges_dropped <= (CW'(oidx_q + 1'b1) == n_q) && ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign stat_o.scan_done  = (idx_q == n_q) && !pend_q;
  assign stat_o.best_valid = bv_q;
  assign stat_o.edge_done  = (eidx_q == ecnt_q);
  assign stat_o.out_fire   = out_valid_q && out_ready_i;
  assign stat_o.out_last   = out_q.last;

  `SSP_ASSERT(a_ecnt_bound, ecnt_q <= EW'(MAX_EDGES), "edge count beyond store size")
  `SSP_NEVER(a_settled_found, (settled_q & ~found_q) != '0, "settled node never reached")
  `SSP_ASSERT(a_last_index, (out_valid_q && out_q.last) |-> (CW'(oidx_q + 1'b1) == n_q),
              "last beat not at final node")

endmodule

// ===== hw/rtl/single_source_shortest_path.sv =====
// Channel   Dir  Handshake            Beat
// in        in   in_valid_i/ready_o   op, from_node, to_node, weight
// out       out  out_valid_o/ready_i  node, distance, reached, flags, last
// cfg       in   APB psel/penable     node_count @0x0, source_node @0x4
//
// Add edge and clear beats are taken back to back while no run is in progress.
// A run repeats a scan of the distance memory, which has a single read port,
// and a three-step relax loop over the edge store, once per settled node.
// Each result beat is read and loaded, then held until out_ready_i takes it.
// Reset clears control state and the edge count; no clearing pass is needed.
module single_source_shortest_path #(
  parameter int unsigned MAX_NODES = ssp_pkg::DefMaxNodes,
  parameter int unsigned MAX_EDGES = ssp_pkg::DefMaxEdges
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ssp_pkg::ssp_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ssp_pkg::ssp_out_t  out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ssp_pkg::*;

  logic [CountW-1:0] node_count_q;
  logic [NodeW-1:0]  source_q;
  logic              cfg_wr;
  ssp_cmd_t          cmd;
  ssp_stat_t         stat;

  // Register file: one word per register, selected by address bit 2.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NodeCountRst;
      source_q     <= SourceRst;
    end else if (cfg_wr) begin
      if (32'(paddr[2]) == RegNodeCount) begin
        node_count_q <= pwdata[CountW-1:0];
      end else if (32'(paddr[2]) == RegSource) begin
        source_q <= pwdata[NodeW-1:0];
      end
    end
  end

  always_comb begin
    if (32'(paddr[2]) == RegNodeCount) begin
      prdata = 32'(node_count_q);
    end else begin
      prdata = 32'(source_q);
    end
  end

  // Sequencer: decode input beats and walk the settle / relax / emit phases.
  ssp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_data_i.op),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Edge store, distance memory, reach and settle bits, result register.
  ssp_dp #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_data_i    (in_data_i),
    .node_count_i (node_count_q),
    .source_i     (source_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule
